// ===== design/lrr_pkg.sv =====
package lrr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS     = 16;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

endpackage

// ===== design/line_run_rasterizer_unit.sv =====
// Line run rasterizer: a request with func_i = 0 loads a segment's endpoints
// (ordered left to right) and gives no result; each request with func_i = 1
// on an active line gives one rectangle on done_o for exactly one cycle,
// which the receiver cannot stall. A request is taken when start_i is high
// and busy_o is low. An accepted step runs COORD_BITS + 2 iterations of the
// radix-2 divider, then registers its result and raises done_o; busy_o stays
// high from acceptance until the result is registered. A load, or a step
// with no active line, completes in its accept cycle. fill_color is written
// through cfg_valid_i, always ready, and should change only while the block
// is idle.
module line_run_rasterizer_unit #(
  parameter int unsigned COORD_BITS = lrr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           func_i,
  input  logic signed [COORD_BITS-1:0]   x_start_i,
  input  logic signed [COORD_BITS-1:0]   y_start_i,
  input  logic signed [COORD_BITS-1:0]   x_end_i,
  input  logic signed [COORD_BITS-1:0]   y_end_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lrr_pkg::COLOR_BITS-1:0] cfg_data_i,
  output logic                           done_o,
  output logic signed [COORD_BITS-1:0]   rect_x_o,
  output logic signed [COORD_BITS:0]     rect_y_o,
  output logic [COORD_BITS:0]            rect_w_o,
  output logic [COORD_BITS:0]            rect_h_o,
  output logic [lrr_pkg::COLOR_BITS-1:0] color_o,
  output logic                           last_run_o
);

  localparam int unsigned C = COORD_BITS;
  localparam int unsigned W = COORD_BITS + 2;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_e;

  state_e                         state_q;
  logic [lrr_pkg::COLOR_BITS-1:0] color_q;
  logic signed [C:0]              cur_col_q, cur_row_q;
  logic signed [C-1:0]            end_col_q, end_row_q;
  logic                           active_q;
  logic                           neg_q, ylong_q;
  logic                           done_q;
  logic signed [C-1:0]            rect_x_q;
  logic signed [C:0]              rect_y_q;
  logic [C:0]                     rect_w_q, rect_h_q;
  logic                           last_q;

  logic                 accept;
  logic                 swap;
  logic signed [W-1:0]  ccol, crow, ecol, erow;
  logic signed [W-1:0]  span_w, dy;
  logic [W-1:0]         span_wu, mag;
  logic                 neg, ylong, past_end;
  logic                 div_start, div_done;
  logic [W-1:0]         num, den, quo;
  logic signed [W-1:0]  run_w, run_h, new_col, new_row, top_row;

  assign accept = start_i && (state_q == S_IDLE);
  assign swap   = x_start_i > x_end_i;

  always_comb begin
    ccol     = W'(cur_col_q);
    crow     = W'(cur_row_q);
    ecol     = W'(end_col_q);
    erow     = W'(end_row_q);
    past_end = ccol > ecol;
    span_w   = ecol - ccol + W'(1);
    dy       = erow - crow;
    neg      = dy < 0;
    span_wu  = $unsigned(span_w);
    mag      = neg ? $unsigned(W'(1) - dy) : $unsigned(dy + W'(1));
    ylong    = mag > span_wu;
    num      = ylong ? mag : span_wu;
    den      = ylong ? span_wu : mag;
  end

  assign div_start = accept && (func_i == lrr_pkg::FUNC_STEP) && active_q && !past_end;

  lrr_divider #(
    .W (W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    run_w   = ylong_q ? W'(1) : $signed(quo);
    run_h   = ylong_q ? $signed(quo) : W'(1);
    new_col = ccol + run_w;
    new_row = neg_q ? (crow - run_h) : (crow + run_h);
    top_row = neg_q ? new_row : crow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      color_q   <= '0;
      cur_col_q <= '0;
      cur_row_q <= '0;
      end_col_q <= '0;
      end_row_q <= '0;
      active_q  <= 1'b0;
      neg_q     <= 1'b0;
      ylong_q   <= 1'b0;
      done_q    <= 1'b0;
      rect_x_q  <= '0;
      rect_y_q  <= '0;
      rect_w_q  <= '0;
      rect_h_q  <= '0;
      last_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (func_i == lrr_pkg::FUNC_LOAD) begin
              cur_col_q <= swap ? (C+1)'(x_end_i) : (C+1)'(x_start_i);
              cur_row_q <= swap ? (C+1)'(y_end_i) : (C+1)'(y_start_i);
              end_col_q <= swap ? x_start_i : x_end_i;
              end_row_q <= swap ? y_start_i : y_end_i;
              active_q  <= 1'b1;
            end else if (!active_q || past_end) begin
              active_q <= 1'b0;
            end else begin
              neg_q   <= neg;
              ylong_q <= ylong;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            rect_x_q  <= cur_col_q[C-1:0];
            rect_y_q  <= top_row[C:0];
            rect_w_q  <= run_w[C:0];
            rect_h_q  <= run_h[C:0];
            last_q    <= new_col > ecol;
            cur_col_q <= new_col[C:0];
            cur_row_q <= new_row[C:0];
            if (new_col > ecol) begin
              active_q <= 1'b0;
            end
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rect_x_o    = rect_x_q;
  assign rect_y_o    = rect_y_q;
  assign rect_w_o    = rect_w_q;
  assign rect_h_o    = rect_h_q;
  assign color_o     = color_q;
  assign last_run_o  = last_q;

endmodule

// ===== design/lrr_divider.sv =====
module lrr_divider #(
  parameter int unsigned W = lrr_pkg::COORD_BITS_DEF + 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  // one restoring step per cycle
  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, den_q};
    if (!diff[W]) begin
      rem_d = diff[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b1};
    end else begin
      rem_d = shifted[W-1:0];
      quo_d = {quo_q[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
